[sv/perspective_project_snap_macros.svh]
// assertion macros for the perspective projection block
// used by the port checker; needs nothing else
`ifndef PERSPECTIVE_PROJECT_SNAP_MACROS_SVH
`define PERSPECTIVE_PROJECT_SNAP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PPS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("perspective_project_snap: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define PPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("perspective_project_snap: next-cycle check failed");

`endif

[sv/pps_pkg.sv]
// shared types and constants of the perspective projection block
// standalone; imported by the controller, the datapath, the top level and the checker
`default_nettype none

package pps_pkg;

    // best distance after reset or a new frame
    localparam logic [14:0] DIST_INIT  = 15'h7FFF;
    // reciprocals for the distance estimate: /100 as *M>>30, /3 as *M>>16
    localparam logic [23:0] RECIP_100  = 24'd10737419;
    localparam logic [14:0] RECIP_3    = 15'd21846;
    // sequencer limits
    localparam logic [4:0]  DIV_LAST   = 5'd16;
    localparam logic [4:0]  DIST_LAST  = 5'd3;
    localparam logic [4:0]  PROD_LO    = 5'd0;
    localparam logic [4:0]  PROD_HI    = 5'd1;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SIN_YAW   = 3'd0,
        CFG_COS_YAW   = 3'd1,
        CFG_SIN_PITCH = 3'd2,
        CFG_COS_PITCH = 3'd3,
        CFG_FOCAL     = 3'd4,
        CFG_SNAP_EN   = 3'd5,
        CFG_TARGET_H  = 3'd6,
        CFG_TARGET_V  = 3'd7
    } t_cfg_idx;

    // multiplier operations: coefficient products, rotation terms, numerator halves
    typedef enum logic [3:0] {
        MOP_CSP = 4'd0,
        MOP_SSP = 4'd1,
        MOP_CCP = 4'd2,
        MOP_SCP = 4'd3,
        MOP_X0  = 4'd4,
        MOP_X1  = 4'd5,
        MOP_Y0  = 4'd6,
        MOP_Y1  = 4'd7,
        MOP_Y2  = 4'd8,
        MOP_Z0  = 4'd9,
        MOP_Z1  = 4'd10,
        MOP_Z2  = 4'd11,
        MOP_NLO = 4'd12,
        MOP_NHI = 4'd13
    } t_mop;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
        logic               new_frame;
    } t_vertex_req;

    typedef struct packed {
        logic signed [15:0] screen_h;
        logic signed [15:0] screen_v;
        logic        [30:0] depth_out;
        logic               behind_camera;
        logic        [14:0] best_distance_out;
        logic signed [15:0] best_h_out;
        logic signed [15:0] best_v_out;
        logic signed [31:0] best_x_out;
        logic signed [31:0] best_y_out;
        logic signed [31:0] best_z_out;
    } t_result_req;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul_go;
        t_mop mop;
        logic check;
        logic setup;
        logic sel_y;
        logic div_init;
        logic div_step;
        logic store;
        logic best_upd;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic z_nonpos;
    } t_status;

endpackage

`default_nettype wire

[sv/perspective_project_snap.sv]
// top level of the perspective projection block with nearest-vertex pick
// depends on pps_pkg, pps_ctrl and pps_datapath
//
// One vertex is worked at a time. A vertex in front of the camera goes from acceptance
// to the result register through the rotation products on the shared 33x33 multiplier,
// then for each screen axis through focal * numerator on the multiplier and the
// radix-2 divider, and then through the distance estimate. A vertex at or behind the
// camera plane skips the projection and the distance estimate. The result sits in an
// output register, so a new vertex is taken while the last result waits.
`default_nettype none

module perspective_project_snap import pps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_vertex_req i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_result_req o_out_data,
    input  logic        i_out_stall,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // sequencer
    pps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // arithmetic and state
    pps_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

[sv/pps_ctrl.sv]
// sequencing state machine of the perspective projection block
// depends on pps_pkg; drives the datapath through t_cmd
`default_nettype none

module pps_ctrl import pps_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_ROT   = 10'b00_0000_0010,
        S_DRAIN = 10'b00_0000_0100,
        S_CHECK = 10'b00_0000_1000,
        S_SETUP = 10'b00_0001_0000,
        S_PROD  = 10'b00_0010_0000,
        S_DIV   = 10'b00_0100_0000,
        S_STORE = 10'b00_1000_0000,
        S_DIST  = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } t_state;

    t_state     r_state, n_state;
    t_mop       r_mop, n_mop;
    logic [4:0] r_cnt, n_cnt;
    logic       r_pass, n_pass;
    logic       r_ovld, n_ovld;

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mop   <= MOP_CSP;
            r_cnt   <= '0;
            r_pass  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mop   <= n_mop;
            r_cnt   <= n_cnt;
            r_pass  <= n_pass;
            r_ovld  <= n_ovld;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_mop   = r_mop;
        n_cnt   = r_cnt;
        n_pass  = r_pass;
        n_ovld  = r_ovld && i_out_stall;
        o_cmd   = '0;
        o_cmd.mop = r_mop;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_mop      = MOP_CSP;
                    n_state    = S_ROT;
                end
            end
            S_ROT: begin
                o_cmd.mul_go = 1'b1;
                if (r_mop == MOP_Z2) begin
                    n_state = S_DRAIN;
                end else begin
                    n_mop = t_mop'(r_mop + 4'd1);
                end
            end
            S_DRAIN: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_pass      = 1'b0;
                if (i_status.z_nonpos) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                o_cmd.sel_y = r_pass;
                n_cnt       = '0;
                n_state     = S_PROD;
            end
            S_PROD: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == PROD_LO) begin
                    o_cmd.mul_go = 1'b1;
                    o_cmd.mop    = MOP_NLO;
                end else if (r_cnt == PROD_HI) begin
                    o_cmd.mul_go = 1'b1;
                    o_cmd.mop    = MOP_NHI;
                end else begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    o_cmd.div_init = 1'b1;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
                if (r_cnt == DIV_LAST) begin
                    n_cnt   = '0;
                    n_state = S_STORE;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                o_cmd.sel_y = r_pass;
                n_cnt       = '0;
                if (!r_pass) begin
                    n_pass  = 1'b1;
                    n_state = S_SETUP;
                end else begin
                    n_state = S_DIST;
                end
            end
            S_DIST: begin
                if (r_cnt == DIST_LAST) begin
                    o_cmd.best_upd = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_DONE: begin
                if (!r_ovld || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_ovld         = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovld;

endmodule

`default_nettype wire

[sv/pps_datapath.sv]
// datapath: config registers, shared multiplier, rotation accumulators,
// radix-2 divider, distance estimate, nearest-vertex state, result register; uses pps_pkg
`default_nettype none

module pps_datapath import pps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data,
    input  t_vertex_req i_in_data,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output t_result_req o_out_data
);

    // configuration registers
    logic signed [15:0] r_sin_yaw, r_cos_yaw, r_sin_pitch, r_cos_pitch;
    logic        [30:0] r_focal;
    logic               r_snap_en;
    logic signed [15:0] r_tgt_h, r_tgt_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sin_yaw   <= 16'sd0;
            r_cos_yaw   <= 16'sd16384;
            r_sin_pitch <= 16'sd0;
            r_cos_pitch <= 16'sd16384;
            r_focal     <= 31'd65536;
            r_snap_en   <= 1'b0;
            r_tgt_h     <= 16'sd0;
            r_tgt_v     <= 16'sd0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SIN_YAW:   r_sin_yaw   <= i_cfg_data[15:0];
                CFG_COS_YAW:   r_cos_yaw   <= i_cfg_data[15:0];
                CFG_SIN_PITCH: r_sin_pitch <= i_cfg_data[15:0];
                CFG_COS_PITCH: r_cos_pitch <= i_cfg_data[15:0];
                CFG_FOCAL:     r_focal     <= i_cfg_data;
                CFG_SNAP_EN:   r_snap_en   <= i_cfg_data[0];
                CFG_TARGET_H:  r_tgt_h     <= i_cfg_data[15:0];
                CFG_TARGET_V:  r_tgt_v     <= i_cfg_data[15:0];
                default:       r_snap_en   <= r_snap_en;
            endcase
        end
    end

    // vertex capture
    logic signed [31:0] r_vx, r_vy, r_vz;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vx <= i_in_data.vertex_x;
            r_vy <= i_in_data.vertex_y;
            r_vz <= i_in_data.vertex_z;
        end
    end

    // shared multiplier, one product per cycle
    logic signed [31:0] r_csp, r_ssp, r_ccp, r_scp;
    logic        [62:0] r_mag;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] r_prod;
    logic               r_pvld;
    t_mop               r_pmop;

    always_comb begin
        unique case (i_cmd.mop)
            MOP_CSP: begin mul_a = 33'(r_cos_yaw);   mul_b = 33'(r_sin_pitch); end
            MOP_SSP: begin mul_a = 33'(r_sin_yaw);   mul_b = 33'(r_sin_pitch); end
            MOP_CCP: begin mul_a = 33'(r_cos_yaw);   mul_b = 33'(r_cos_pitch); end
            MOP_SCP: begin mul_a = 33'(r_sin_yaw);   mul_b = 33'(r_cos_pitch); end
            MOP_X0:  begin mul_a = 33'(r_sin_yaw);   mul_b = 33'(r_vx);        end
            MOP_X1:  begin mul_a = 33'(r_cos_yaw);   mul_b = 33'(r_vy);        end
            MOP_Y0:  begin mul_a = 33'(r_csp);       mul_b = 33'(r_vx);        end
            MOP_Y1:  begin mul_a = 33'(r_ssp);       mul_b = 33'(r_vy);        end
            MOP_Y2:  begin mul_a = 33'(r_cos_pitch); mul_b = 33'(r_vz);        end
            MOP_Z0:  begin mul_a = 33'(r_ccp);       mul_b = 33'(r_vx);        end
            MOP_Z1:  begin mul_a = 33'(r_scp);       mul_b = 33'(r_vy);        end
            MOP_Z2:  begin mul_a = 33'(r_sin_pitch); mul_b = 33'(r_vz);        end
            MOP_NLO: begin mul_a = {2'b00, r_focal}; mul_b = {1'b0, r_mag[31:0]}; end
            MOP_NHI: begin mul_a = {2'b00, r_focal}; mul_b = {2'b00, r_mag[62:32]}; end
            default: begin mul_a = '0;               mul_b = '0;               end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_pmop <= i_cmd.mop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_cmd.mul_go;
        end
    end

    // product accumulation: rotation sums at scale 2^-44, projection numerator
    logic signed [63:0] r_accx, r_accy, r_accz;
    logic        [93:0] r_num;
    logic signed [63:0] prod64, prod_sh;

    assign prod64  = r_prod[63:0];
    assign prod_sh = {r_prod[49:0], 14'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_accx <= '0;
            r_accy <= '0;
            r_accz <= '0;
        end else if (r_pvld) begin
            case (r_pmop)
                MOP_CSP: r_csp  <= r_prod[31:0];
                MOP_SSP: r_ssp  <= r_prod[31:0];
                MOP_CCP: r_ccp  <= r_prod[31:0];
                MOP_SCP: r_scp  <= r_prod[31:0];
                MOP_X0:  r_accx <= r_accx - prod_sh;
                MOP_X1:  r_accx <= r_accx + prod_sh;
                MOP_Y0:  r_accy <= r_accy + prod64;
                MOP_Y1:  r_accy <= r_accy + prod64;
                MOP_Y2:  r_accy <= r_accy - prod_sh;
                MOP_Z0:  r_accz <= r_accz + prod64;
                MOP_Z1:  r_accz <= r_accz + prod64;
                MOP_Z2:  r_accz <= r_accz + prod_sh;
                MOP_NLO: r_num  <= {31'b0, r_prod[62:0]};
                MOP_NHI: r_num  <= r_num + {r_prod[61:0], 32'b0};
                default: r_num  <= r_num;
            endcase
        end
    end

    // depth test and depth * 1000, scaled back by 2^-44
    logic        z_nonpos;
    logic [73:0] z_ext, z_1000;
    logic        r_behind;
    logic [30:0] r_depth;

    assign z_nonpos = r_accz[63] || (r_accz == '0);
    assign z_ext    = {11'b0, r_accz[62:0]};
    assign z_1000   = (z_ext << 10) - (z_ext << 4) - (z_ext << 3);
    assign o_status.z_nonpos = z_nonpos;

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_behind <= z_nonpos;
            r_depth  <= {1'b0, z_1000[73:44]};
        end
    end

    // numerator sign and magnitude for the current axis
    logic signed [63:0] num_sel, mag64;
    logic               r_neg;

    assign num_sel = i_cmd.sel_y ? r_accy : r_accx;
    assign mag64   = num_sel[63] ? -num_sel : num_sel;

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_neg <= num_sel[63];
            r_mag <= mag64[62:0];
        end
    end

    // restoring divider, one quotient bit per cycle, top bit flags saturation
    logic [77:0] r_rem, r_den;
    logic [15:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= r_num[93:16];
            r_den <= {r_accz[62:0], 15'b0};
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            if (r_rem >= r_den) begin
                r_rem <= r_rem - r_den;
                r_q   <= {r_q[14:0], 1'b1};
            end else begin
                r_q   <= {r_q[14:0], 1'b0};
            end
            r_den <= r_den >> 1;
        end
    end

    // signed, saturated screen coordinate
    logic        [15:0] proj_val;
    logic signed [15:0] r_h, r_v;

    always_comb begin
        if (r_neg) begin
            proj_val = r_q[15] ? 16'h8000 : (~r_q + 16'd1);
        end else begin
            proj_val = r_q[15] ? 16'h7FFF : r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            if (i_cmd.sel_y) begin
                r_v <= proj_val;
            end else begin
                r_h <= proj_val;
            end
        end
    end

    // octagonal distance estimate, three register stages
    logic signed [16:0] dh_s, dv_s;
    logic        [16:0] dh_a, dv_a;
    logic        [15:0] r_dmax, r_dmin, r_max2, r_max3;
    logic        [21:0] r_m41;
    logic        [27:0] r_mx3;
    logic        [45:0] m100;
    logic        [15:0] r_q100;
    logic        [11:0] r_q24;
    logic        [17:0] dist_est;

    assign dh_s = 17'(r_h) - 17'(r_tgt_h);
    assign dv_s = 17'(r_v) - 17'(r_tgt_v);
    assign dh_a = dh_s[16] ? 17'(-dh_s) : 17'(dh_s);
    assign dv_a = dv_s[16] ? 17'(-dv_s) : 17'(dv_s);
    assign m100 = {24'b0, r_m41} * {22'b0, RECIP_100};
    assign dist_est = {2'b0, r_max3} + {2'b0, r_q100} - {6'b0, r_q24};

    always_ff @(posedge i_clk) begin
        if (dh_a[15:0] > dv_a[15:0]) begin
            r_dmax <= dh_a[15:0];
            r_dmin <= dv_a[15:0];
        end else begin
            r_dmax <= dv_a[15:0];
            r_dmin <= dh_a[15:0];
        end
        r_m41  <= ({6'b0, r_dmin} << 5) + ({6'b0, r_dmin} << 3) + {6'b0, r_dmin};
        r_mx3  <= {15'b0, r_dmax[15:3]} * {13'b0, RECIP_3};
        r_max2 <= r_dmax;
        r_q100 <= m100[45:30];
        r_q24  <= r_mx3[27:16];
        r_max3 <= r_max2;
    end

    // nearest-vertex state
    logic        [14:0] r_best_dist;
    logic signed [15:0] r_best_h, r_best_v;
    logic signed [31:0] r_best_x, r_best_y, r_best_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_dist <= DIST_INIT;
            r_best_h    <= '0;
            r_best_v    <= '0;
            r_best_x    <= '0;
            r_best_y    <= '0;
            r_best_z    <= '0;
        end else if (i_cmd.load && i_in_data.new_frame) begin
            r_best_dist <= DIST_INIT;
        end else if (i_cmd.best_upd && r_snap_en && (dist_est < {3'b0, r_best_dist})) begin
            r_best_dist <= dist_est[14:0];
            r_best_h    <= r_h;
            r_best_v    <= r_v;
            r_best_x    <= r_vx;
            r_best_y    <= r_vy;
            r_best_z    <= r_vz;
        end
    end

    // result register
    t_result_req r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.screen_h          <= r_behind ? 16'sd0 : r_h;
            r_out.screen_v          <= r_behind ? 16'sd0 : r_v;
            r_out.depth_out         <= r_behind ? 31'd0 : r_depth;
            r_out.behind_camera     <= r_behind;
            r_out.best_distance_out <= r_best_dist;
            r_out.best_h_out        <= r_best_h;
            r_out.best_v_out        <= r_best_v;
            r_out.best_x_out        <= r_best_x;
            r_out.best_y_out        <= r_best_y;
            r_out.best_z_out        <= r_best_z;
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

[sv/pps_checker.sv]
// port-level checks of the perspective projection block, bound to the top level
// depends on pps_pkg and perspective_project_snap_macros.svh
`default_nettype none
`include "perspective_project_snap_macros.svh"

module pps_checker import pps_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input t_result_req o_out_data,
    input logic        i_out_stall
);

    // a stalled result stays offered
    `PPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // a stalled result keeps its payload
    `PPS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))

    // an accepted vertex keeps the block busy next cycle
    `PPS_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // a vertex behind the camera reports zero position and depth
    `PPS_ASSERT_IMPLY(a_behind_zero, i_clk, i_rst_n, o_out_valid && o_out_data.behind_camera, (o_out_data.screen_h == 16'sd0) && (o_out_data.screen_v == 16'sd0) && (o_out_data.depth_out == 31'd0))

endmodule

bind perspective_project_snap pps_checker u_pps_checker (.*);

`default_nettype wire

[tb/sv/perspective_project_snap_tb.sv]
// self-checking testbench of the perspective projection block with nearest-vertex pick
// depends on pps_pkg and perspective_project_snap; holds its own projection predictor
`default_nettype none

module perspective_project_snap_tb;
    import pps_pkg::*;

    // projection predictor and store of expected results
    class proj_scoreboard;
        logic signed [15:0] sin_yaw, cos_yaw, sin_pitch, cos_pitch, tgt_h, tgt_v;
        logic        [30:0] focal;
        logic               snap_on;
        logic        [14:0] best_dist;
        logic signed [15:0] best_h, best_v;
        logic signed [31:0] best_x, best_y, best_z;
        t_result_req        pending[$];
        int                 errors;

        function void clear();
            sin_yaw = 0; cos_yaw = 16384; sin_pitch = 0; cos_pitch = 16384;
            focal = 31'd65536; snap_on = 0; tgt_h = 0; tgt_v = 0;
            best_dist = DIST_INIT;
            best_h = 0; best_v = 0; best_x = 0; best_y = 0; best_z = 0;
            pending.delete();
            errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [30:0] val);
            case (idx)
                CFG_SIN_YAW:   sin_yaw = val[15:0];
                CFG_COS_YAW:   cos_yaw = val[15:0];
                CFG_SIN_PITCH: sin_pitch = val[15:0];
                CFG_COS_PITCH: cos_pitch = val[15:0];
                CFG_FOCAL:     focal = val;
                CFG_SNAP_EN:   snap_on = val[0];
                CFG_TARGET_H:  tgt_h = val[15:0];
                CFG_TARGET_V:  tgt_v = val[15:0];
                default: ;
            endcase
        endfunction

        // view depth at scale 2^-44
        function longint view_depth(t_vertex_req r);
            longint sy, cy, sp, cp;
            sy = sin_yaw; cy = cos_yaw; sp = sin_pitch; cp = cos_pitch;
            return (cy * cp) * longint'(r.vertex_x) + (sy * cp) * longint'(r.vertex_y)
                + (sp * longint'(r.vertex_z)) * 16384;
        endfunction

        // trunc(focal * num / (den * 2^16)), saturated to 16 bits
        function logic signed [15:0] screen_pos(longint num, longint den);
            logic [127:0] mag, n, q, fw, dw;
            mag = (num < 0) ? 128'(-num) : 128'(num);
            fw = 128'(focal);
            dw = 128'(den);
            n = (mag * fw) >> 16;
            q = n / dw;
            if (q > 128'd32768) q = 128'd32768;
            if (num < 0) return -q[15:0];
            if (q > 128'd32767) q = 128'd32767;
            return q[15:0];
        endfunction

        function void note_vertex(t_vertex_req r);
            t_result_req res;
            longint sy, cy, sp, cp, vx, vy, vz, x_rot, y_rot, z_rot;
            logic [127:0] dz;
            int dh, dv, d;
            sy = sin_yaw; cy = cos_yaw; sp = sin_pitch; cp = cos_pitch;
            vx = r.vertex_x; vy = r.vertex_y; vz = r.vertex_z;
            if (r.new_frame) best_dist = DIST_INIT;
            x_rot = (-sy * vx + cy * vy) * 16384;
            y_rot = (cy * sp) * vx + (sy * sp) * vy - (cp * vz) * 16384;
            z_rot = view_depth(r);
            res = '0;
            res.behind_camera = (z_rot <= 0);
            if (z_rot > 0) begin
                res.screen_h = screen_pos(x_rot, z_rot);
                res.screen_v = screen_pos(y_rot, z_rot);
                dz = (128'(z_rot) * 128'd1000) >> 44;
                res.depth_out = (dz > 128'h7FFFFFFF) ? 31'h7FFFFFFF : dz[30:0];
                if (snap_on) begin
                    dh = int'(res.screen_h) - int'(tgt_h);
                    dv = int'(res.screen_v) - int'(tgt_v);
                    if (dh < 0) dh = -dh;
                    if (dv < 0) dv = -dv;
                    d = (dh > dv) ? dh + dv * 41 / 100 - dh / 24
                                  : dv + dh * 41 / 100 - dv / 24;
                    if (d < int'(best_dist)) begin
                        best_dist = d[14:0];
                        best_h = res.screen_h; best_v = res.screen_v;
                        best_x = r.vertex_x; best_y = r.vertex_y; best_z = r.vertex_z;
                    end
                end
            end
            res.best_distance_out = best_dist;
            res.best_h_out = best_h; res.best_v_out = best_v;
            res.best_x_out = best_x; res.best_y_out = best_y; res.best_z_out = best_z;
            pending.push_back(res);
        endfunction

        function void check_result(t_result_req got);
            t_result_req exp_res;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (got.screen_h !== exp_res.screen_h)
                $display("%0t: screen_h exp %0d got %0d", $time,
                         exp_res.screen_h, got.screen_h);
            if (got.screen_v !== exp_res.screen_v)
                $display("%0t: screen_v exp %0d got %0d", $time,
                         exp_res.screen_v, got.screen_v);
            if (got.depth_out !== exp_res.depth_out)
                $display("%0t: depth_out exp %0d got %0d", $time,
                         exp_res.depth_out, got.depth_out);
            if (got.behind_camera !== exp_res.behind_camera)
                $display("%0t: behind_camera exp %0d got %0d", $time,
                         exp_res.behind_camera, got.behind_camera);
            if (got.best_distance_out !== exp_res.best_distance_out)
                $display("%0t: best_distance exp %0d got %0d", $time,
                         exp_res.best_distance_out, got.best_distance_out);
            if (got.best_h_out !== exp_res.best_h_out)
                $display("%0t: best_h exp %0d got %0d", $time,
                         exp_res.best_h_out, got.best_h_out);
            if (got.best_v_out !== exp_res.best_v_out)
                $display("%0t: best_v exp %0d got %0d", $time,
                         exp_res.best_v_out, got.best_v_out);
            if (got.best_x_out !== exp_res.best_x_out)
                $display("%0t: best_x exp %h got %h", $time,
                         exp_res.best_x_out, got.best_x_out);
            if (got.best_y_out !== exp_res.best_y_out)
                $display("%0t: best_y exp %h got %h", $time,
                         exp_res.best_y_out, got.best_y_out);
            if (got.best_z_out !== exp_res.best_z_out)
                $display("%0t: best_z exp %h got %h", $time,
                         exp_res.best_z_out, got.best_z_out);
            if (got !== exp_res) errors++;
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        i_in_valid, o_in_stall, o_out_valid, i_out_stall;
    t_vertex_req i_in_data;
    t_result_req o_out_data;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [30:0] i_cfg_data;

    proj_scoreboard sb;
    int in_idle_pct, out_idle_pct;

    perspective_project_snap dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_data(i_in_data), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .o_out_data(o_out_data), .i_out_stall(i_out_stall),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #20000000;
        $display("FAILURE");
        $finish;
    end

    // result side: check accepted results, stall at random
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
            i_out_stall <= ($urandom_range(0, 99) < out_idle_pct);
        end
    end

    // register write, enable is lowered by the caller after a batch
    task automatic write_reg(t_cfg_idx idx, logic [30:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // send one request, gaps at random
    task automatic send_vertex(t_vertex_req r);
        if ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < in_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_vertex(r);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic t_vertex_req mk_vertex(logic [31:0] x, logic [31:0] y,
                                               logic [31:0] z, logic nf);
        t_vertex_req r;
        r.vertex_x = x; r.vertex_y = y; r.vertex_z = z; r.new_frame = nf;
        return r;
    endfunction

    // random vertex: mostly moderate magnitudes and in front, some raw noise
    function automatic t_vertex_req rand_vertex();
        t_vertex_req r;
        int sh;
        sh = $urandom_range(0, 24);
        r.vertex_x = $signed($urandom()) >>> sh;
        r.vertex_y = $signed($urandom()) >>> ($urandom_range(0, 3) == 0 ? 0 : sh + 2);
        r.vertex_z = $signed($urandom()) >>> ($urandom_range(0, 3) == 0 ? 0 : sh + 2);
        r.new_frame = ($urandom_range(0, 99) < 8);
        if ($urandom_range(0, 4) != 0 && sb.view_depth(r) < 0) begin
            r.vertex_x = -r.vertex_x; r.vertex_y = -r.vertex_y; r.vertex_z = -r.vertex_z;
        end
        return r;
    endfunction

    function automatic logic [30:0] rand_trig();
        logic signed [15:0] s;
        s = $urandom_range(0, 32768) - 16384;
        return {15'b0, s};
    endfunction

    initial begin
        sb = new();
        sb.clear();
        in_idle_pct = 23;
        out_idle_pct = 52;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_SIN_YAW;
        i_cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: default camera, snap on at the origin
        write_reg(CFG_SNAP_EN, 31'd1);
        end_writes();
        send_vertex(mk_vertex(32'h0001_0000, 32'h0, 32'h0, 1'b1));
        send_vertex(mk_vertex(32'h0001_0000, 32'h0000_8000, 32'hFFFF_8000, 1'b0));
        send_vertex(mk_vertex(32'h0, 32'h0001_0000, 32'h0, 1'b0));
        send_vertex(mk_vertex(32'hFFFF_0000, 32'h0, 32'h0, 1'b0));
        send_vertex(mk_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        send_vertex(mk_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
        send_vertex(mk_vertex(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        send_vertex(mk_vertex(32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
        send_vertex(mk_vertex(32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0));
        send_vertex(mk_vertex(32'h0010_0000, 32'h0003_0000, 32'h0001_0000, 1'b0));
        send_vertex(mk_vertex(32'h0010_0000, 32'h0003_0000, 32'h0001_0000, 1'b1));
        send_vertex(mk_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        drain();
        // focal extremes
        write_reg(CFG_FOCAL, 31'h7FFF_FFFF);
        write_reg(CFG_TARGET_H, 31'h7FFF);
        write_reg(CFG_TARGET_V, {15'b0, 16'h8000});
        end_writes();
        send_vertex(mk_vertex(32'h0001_0000, 32'h0000_0100, 32'h0000_0100, 1'b1));
        send_vertex(mk_vertex(32'h0001_0000, 32'h8000_0000, 32'h0, 1'b0));
        send_vertex(mk_vertex(32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0));
        drain();
        write_reg(CFG_FOCAL, 31'd0);
        end_writes();
        send_vertex(mk_vertex(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        drain();

        // random phases with different camera settings
        for (int ph = 0; ph < 6; ph++) begin
            in_idle_pct = (ph < 2) ? 23 : (ph < 4) ? 52 : 0;
            out_idle_pct = (ph < 2) ? 52 : (ph < 4) ? 23 : 0;
            case (ph)
                0: begin
                    write_reg(CFG_SIN_YAW, {15'b0, 16'hC000});
                    write_reg(CFG_COS_YAW, 31'd0);
                    write_reg(CFG_SIN_PITCH, 31'd16384);
                    write_reg(CFG_COS_PITCH, 31'd0);
                    write_reg(CFG_FOCAL, 31'h7FFF_FFFF);
                end
                1: begin
                    write_reg(CFG_SIN_YAW, {15'b0, 16'hC000});
                    write_reg(CFG_COS_YAW, {15'b0, 16'hC000});
                    write_reg(CFG_SIN_PITCH, {15'b0, 16'hC000});
                    write_reg(CFG_COS_PITCH, {15'b0, 16'hC000});
                    write_reg(CFG_SNAP_EN, 31'd0);
                end
                default: begin
                    write_reg(CFG_SIN_YAW, rand_trig());
                    write_reg(CFG_COS_YAW, rand_trig());
                    write_reg(CFG_SIN_PITCH, rand_trig());
                    write_reg(CFG_COS_PITCH, rand_trig());
                    write_reg(CFG_FOCAL, $urandom_range(0, 3) == 0 ?
                              31'($urandom()) : 31'($urandom_range(1 << 16, 1 << 26)));
                    write_reg(CFG_SNAP_EN, 31'(ph != 3));
                end
            endcase
            write_reg(CFG_TARGET_H, {15'b0, 16'($signed($urandom_range(0, 800)) - 400)});
            write_reg(CFG_TARGET_V, {15'b0, 16'($signed($urandom_range(0, 800)) - 400)});
            end_writes();
            for (int k = 0; k < 88; k++) send_vertex(rand_vertex());
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
